/* rtl/ucpd_pkg.sv */
// shared types and constants of the utf code point decoder
package ucpd_pkg;

    localparam longint unsigned MAX_TEXT_BYTES = 64'd1048576;
    localparam int POS_W       = $clog2(MAX_TEXT_BYTES + 1);
    localparam int OFF_W       = 20;
    localparam int CP_W        = 32;
    localparam int CNT_W       = 21;
    localparam int SIZE_W      = 3;
    localparam int RES_SLOTS   = 3;
    localparam int SLOT_W      = $clog2(RES_SLOTS);
    localparam int RCNT_W      = $clog2(RES_SLOTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int TDATA_W     = 80;
    localparam int TUSER_W     = 2;
    localparam int APB_AW      = 3;

    localparam logic [CNT_W-1:0] MAX_CP_RESET = 21'd1048576;
    localparam logic [CP_W-1:0]  REPLACEMENT  = 32'h0000_FFFD;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_MAX  = 1'b1;

    typedef enum logic [1:0] {
        MODE_UTF8  = 2'd0,
        MODE_UTF16 = 2'd1,
        MODE_UTF32 = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] max_cp;
        logic             mode_wr;
    } cfg_t;

    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
    } slot_t;

    // one queue entry: every result caused by one input byte
    typedef struct packed {
        slot_t [RES_SLOTS-1:0] slot;
        logic [RCNT_W-1:0]     cnt;
        logic [CNT_W-1:0]      base;
        logic                  has_cp;
        logic                  eot;
    } rec_t;

endpackage

/* rtl/ucpd_front.sv */
// front end: takes bytes, tracks per-text state and builds at most one record per byte
module ucpd_front
    import ucpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output rec_t       push_rec
);

    localparam logic [7:0] MASK_80 = 8'b1000_0000;
    localparam logic [7:0] MASK_E0 = 8'b1110_0000;
    localparam logic [7:0] MASK_F0 = 8'b1111_0000;
    localparam logic [7:0] MASK_F8 = 8'b1111_1000;
    localparam logic [7:0] TAG_C0  = 8'b1100_0000;
    localparam logic [7:0] TAG_E0  = 8'b1110_0000;
    localparam logic [7:0] TAG_F0  = 8'b1111_0000;
    localparam logic [5:0] HIGH_TAG = 6'b110110;
    localparam logic [5:0] LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 32'h0001_0000;
    localparam logic [POS_W-1:0] POS_LIMIT = MAX_TEXT_BYTES[POS_W-1:0];

    typedef struct packed {
        logic [20:0]       cp;
        logic [SIZE_W-1:0] size;
    } dec_t;

    function automatic logic [SIZE_W-1:0] lead_len(input logic [7:0] b);
        logic [SIZE_W-1:0] n;
        n = 3'd1;
        if ((b & MASK_80) == 8'h00)
            n = 3'd1;
        else if ((b & MASK_E0) == TAG_C0)
            n = 3'd2;
        else if ((b & MASK_F0) == TAG_E0)
            n = 3'd3;
        else if ((b & MASK_F8) == TAG_F0)
            n = 3'd4;
        return n;
    endfunction

    function automatic dec_t decode8(input logic [7:0] b0, input logic [7:0] b1,
                                     input logic [7:0] b2, input logic [7:0] b3,
                                     input logic [2:0] avail);
        dec_t d;
        d.cp   = REPLACEMENT[20:0];
        d.size = 3'd1;
        if (avail == 3'd0)
        begin
            d.cp   = '0;
            d.size = 3'd0;
        end
        else if ((b0 & MASK_80) == 8'h00)
        begin
            d.cp = 21'(b0);
        end
        else if (avail >= 3'd2 && (b0 & MASK_E0) == TAG_C0)
        begin
            d.cp   = 21'({b0[4:0], b1[5:0]});
            d.size = 3'd2;
        end
        else if (avail >= 3'd3 && (b0 & MASK_F0) == TAG_E0)
        begin
            d.cp   = 21'({b0[3:0], b1[5:0], b2[5:0]});
            d.size = 3'd3;
        end
        else if (avail >= 3'd4 && (b0 & MASK_F8) == TAG_F0)
        begin
            d.cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            d.size = 3'd4;
        end
        return d;
    endfunction

    function automatic logic [7:0] pick(input logic [2:0][7:0] v, input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = v[0];
            3'd1:    r = v[1];
            3'd2:    r = v[2];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    logic [2:0][7:0]    pend_reg, pend_next;
    logic [1:0]         pc_reg, pc_next;
    logic [SIZE_W-1:0]  nl_reg, nl_next;
    logic [9:0]         hs_reg, hs_next;
    logic               sw_reg, sw_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   tot_reg;
    logic               lim_reg;
    logic [OFF_W-1:0]   us_reg, us_next;
    logic [OFF_W-1:0]   hst_reg, hst_next;

    logic               accept;
    logic               take;
    logic [SIZE_W-1:0]  nl_eff;
    logic [15:0]        unit_w;
    logic               paired;
    dec_t               dec;
    logic [2:0]         idx;
    slot_t [RES_SLOTS-1:0] cand;
    logic [RCNT_W-1:0]  ncand;
    logic [CNT_W-1:0]   room;
    logic               over;
    logic [RCNT_W-1:0]  kept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        take      = pos_reg < POS_LIMIT;
        pos_next  = take ? pos_reg + POS_W'(1) : pos_reg;
        pend_next = pend_reg;
        pc_next   = pc_reg;
        nl_next   = nl_reg;
        hs_next   = hs_reg;
        sw_next   = sw_reg;
        us_next   = us_reg;
        hst_next  = hst_reg;
        cand      = '0;
        ncand     = '0;
        nl_eff    = nl_reg;
        unit_w    = {in_byte, pend_reg[0]};
        paired    = 1'b0;
        dec       = '0;
        idx       = '0;

        unique case (cfg.mode)
            MODE_UTF8:
            begin
                if (take)
                begin
                    if (pc_reg == 2'd0)
                    begin
                        us_next = OFF_W'(pos_reg);
                        nl_eff  = lead_len(in_byte);
                    end
                    if ({1'b0, pc_reg} + 3'd1 >= nl_eff || pc_reg == 2'd3)
                    begin
                        dec = decode8((pc_reg == 2'd0) ? in_byte : pend_reg[0],
                                      (pc_reg == 2'd1) ? in_byte : pend_reg[1],
                                      (pc_reg == 2'd2) ? in_byte : pend_reg[2],
                                      in_byte, {1'b0, pc_reg} + 3'd1);
                        cand[0] = '{cp: CP_W'(dec.cp), off: us_next, size: dec.size};
                        ncand   = RCNT_W'(1);
                        pc_next = 2'd0;
                        nl_next = '0;
                    end
                    else
                    begin
                        pend_next[pc_reg] = in_byte;
                        pc_next           = pc_reg + 2'd1;
                        nl_next           = nl_eff;
                    end
                end
                // end of text inside a sequence: rescan what is pending
                if (in_last)
                begin
                    for (int k = 0; k < RES_SLOTS; k++)
                    begin
                        if (idx < {1'b0, pc_next})
                        begin
                            dec = decode8(pick(pend_next, idx), pick(pend_next, idx + 3'd1),
                                          pick(pend_next, idx + 3'd2), 8'h00,
                                          {1'b0, pc_next} - idx);
                            cand[k] = '{cp: CP_W'(dec.cp), off: us_next + OFF_W'(idx),
                                        size: dec.size};
                            ncand   = RCNT_W'(k + 1);
                            idx     = idx + dec.size;
                        end
                    end
                end
            end
            MODE_UTF16:
            begin
                if (take)
                begin
                    if (pc_reg == 2'd0)
                    begin
                        us_next      = OFF_W'(pos_reg);
                        pend_next[0] = in_byte;
                        pc_next      = 2'd1;
                    end
                    else
                    begin
                        pc_next = 2'd0;
                        if (sw_reg)
                        begin
                            sw_next = 1'b0;
                            if (unit_w[15:10] == LOW_TAG)
                            begin
                                cand[0] = '{cp: SUPP_BASE + CP_W'({hs_reg, unit_w[9:0]}),
                                            off: hst_reg, size: 3'd4};
                                paired  = 1'b1;
                            end
                            else
                            begin
                                cand[0] = '{cp: REPLACEMENT, off: hst_reg, size: 3'd2};
                            end
                            ncand = RCNT_W'(1);
                        end
                        if (!paired)
                        begin
                            if (unit_w[15:10] == HIGH_TAG)
                            begin
                                hs_next  = unit_w[9:0];
                                hst_next = us_reg;
                                sw_next  = 1'b1;
                            end
                            else
                            begin
                                cand[ncand[SLOT_W-1:0]] = '{cp: CP_W'(unit_w), off: us_reg,
                                                            size: 3'd2};
                                ncand = ncand + RCNT_W'(1);
                            end
                        end
                    end
                end
                if (in_last && sw_next)
                begin
                    cand[ncand[SLOT_W-1:0]] = '{cp: REPLACEMENT, off: hst_next, size: 3'd2};
                    ncand = ncand + RCNT_W'(1);
                end
            end
            MODE_UTF32:
            begin
                if (take)
                begin
                    if (pc_reg == 2'd0)
                        us_next = OFF_W'(pos_reg);
                    if (pc_reg != 2'd3)
                    begin
                        pend_next[pc_reg] = in_byte;
                        pc_next           = pc_reg + 2'd1;
                    end
                    else
                    begin
                        cand[0] = '{cp: {in_byte, pend_reg[2], pend_reg[1], pend_reg[0]},
                                    off: us_reg, size: 3'd4};
                        ncand   = RCNT_W'(1);
                        pc_next = 2'd0;
                    end
                end
            end
            MODE_NONE:
            begin
                pc_next = pc_reg;
            end
        endcase

        // code point limit
        room = (lim_reg || tot_reg >= cfg.max_cp) ? '0 : cfg.max_cp - tot_reg;
        over = CNT_W'(ncand) > room;
        kept = over ? room[RCNT_W-1:0] : ncand;

        push_rec.slot   = cand;
        push_rec.cnt    = kept;
        push_rec.base   = tot_reg;
        push_rec.has_cp = 1'b1;
        push_rec.eot    = in_last;
        if (kept == '0)
        begin
            push_rec.slot[0] = '{cp: '0, off: OFF_W'(pos_next), size: '0};
            push_rec.cnt     = RCNT_W'(1);
            push_rec.has_cp  = 1'b0;
        end
        push = accept && (kept != '0 || in_last);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            nl_reg  <= '0;
            hs_reg  <= '0;
            sw_reg  <= 1'b0;
            pos_reg <= '0;
            tot_reg <= '0;
            lim_reg <= 1'b0;
            us_reg  <= '0;
            hst_reg <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                pc_reg  <= '0;
                nl_reg  <= '0;
                hs_reg  <= '0;
                sw_reg  <= 1'b0;
                pos_reg <= '0;
                tot_reg <= '0;
                lim_reg <= 1'b0;
                us_reg  <= '0;
                hst_reg <= '0;
            end
            else
            begin
                pc_reg  <= pc_next;
                nl_reg  <= nl_next;
                hs_reg  <= hs_next;
                sw_reg  <= sw_next;
                pos_reg <= pos_next;
                tot_reg <= tot_reg + CNT_W'(kept);
                lim_reg <= lim_reg || over;
                us_reg  <= us_next;
                hst_reg <= hst_next;
            end
        end
        else if (cfg.mode_wr)
        begin
            pc_reg <= '0;
            nl_reg <= '0;
            sw_reg <= 1'b0;
        end
    end

endmodule

/* rtl/ucpd_fifo.sv */
// short record queue between front end and back end
module ucpd_fifo
    import ucpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output rec_t head_rec
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    rec_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_rec   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= bump(wr_reg);
            if (pop)
                rd_reg <= bump(rd_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* rtl/ucpd_back.sv */
// back end: steps through the results of each record into the output register
module ucpd_back
    import ucpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  rec_t               head_rec,
    output logic               pop,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // code_point, start_offset, unit_bytes, points_so_far
    output logic               m_axis_tlast,
    output logic [TUSER_W-1:0] m_axis_tuser   // has_code_point, text_done
);

    logic [SLOT_W-1:0] k_reg;
    logic              ov_reg;
    logic [CP_W-1:0]   cp_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  pts_reg;
    logic              has_reg;
    logic              last_reg;
    logic              done_reg;

    logic              load;
    logic              last_k;
    slot_t             cur;

    assign load   = head_valid && (!ov_reg || m_axis_tready);
    assign cur    = head_rec.slot[k_reg];
    assign last_k = RCNT_W'(k_reg) == head_rec.cnt - RCNT_W'(1);
    assign pop    = load && last_k;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= cur.cp;
            off_reg  <= cur.off;
            size_reg <= cur.size;
            pts_reg  <= head_rec.has_cp ? head_rec.base + CNT_W'(k_reg) + CNT_W'(1)
                                        : head_rec.base;
            has_reg  <= head_rec.has_cp;
            last_reg <= last_k;
            done_reg <= head_rec.eot && last_k;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (load)
        begin
            k_reg  <= last_k ? '0 : k_reg + SLOT_W'(1);
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {(TDATA_W - CP_W - OFF_W - SIZE_W - CNT_W)'(0),
                            pts_reg, size_reg, off_reg, cp_reg};
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = {done_reg, has_reg};

`ifndef SYNTHESIS
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> RCNT_W'(k_reg) < head_rec.cnt)
        else $error("slot index beyond record count");

    a_bare_marker_ends_text: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !has_reg |-> last_reg && done_reg && size_reg == '0)
        else $error("bare end marker not closing the text");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && done_reg |-> last_reg)
        else $error("text done on a beat that is not last of its run");

    a_size_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && has_reg |-> size_reg != '0 && size_reg <= 3'd4)
        else $error("code point with bad byte count");
`endif

endmodule

/* rtl/utf_code_point_decoder_unit.sv */
// UTF code point decoder: takes one byte per cycle and emits decoded code points.
// A byte is taken in every cycle while the 4-entry record queue between the front end
// and the back end has room. Each byte that causes results leaves one record in the
// queue, and the back end moves one result per cycle into the output register while
// the output is not stalled. A byte gives at most three results (only at the end of a
// text), and the output drains one beat per cycle unless stalled, which sets the long-
// run rate when many short texts arrive back to back. There is no clearing pass after
// reset. encoding_mode sits at byte address 0 and max_code_points at byte address 4.
module utf_code_point_decoder_unit
    import ucpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // data_byte
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // code_point, start_offset, unit_bytes, points_so_far
    output logic               m_axis_tlast,
    output logic [TUSER_W-1:0] m_axis_tuser,  // has_code_point, text_done
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    mode_t            mode_reg;
    logic [CNT_W-1:0] max_reg;
    logic             cfg_wr;
    cfg_t             cfg;

    logic             q_full;
    logic             q_push;
    rec_t             q_push_rec;
    logic             q_pop;
    logic             q_valid;
    rec_t             q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UTF8;
            max_reg  <= MAX_CP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MODE: mode_reg <= mode_t'(pwdata[1:0]);
                REG_MAX:  max_reg  <= pwdata[CNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE: prdata = 32'(mode_reg);
            REG_MAX:  prdata = 32'(max_reg);
        endcase
    end

    assign cfg.mode    = mode_reg;
    assign cfg.max_cp  = max_reg;
    assign cfg.mode_wr = cfg_wr && (paddr[2] == REG_MODE);

    ucpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .in_ready (s_axis_tready),
        .push     (q_push),
        .push_rec (q_push_rec)
    );

    ucpd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_rec   (q_push_rec),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_rec   (q_head)
    );

    ucpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (q_valid),
        .head_rec      (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
